[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock once out of reset
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition that must never be seen once out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

[src/gfr_pkg.sv]
package gfr_pkg;

    localparam int DISP_W      = 128;
    localparam int DISP_H      = 64;
    localparam int GLYPH_W     = 5;
    localparam int GLYPH_H     = 7;
    localparam int FIRST_CODE  = 32;
    localparam int LAST_CODE   = 127;

    localparam int FRAME_DEPTH = 1024;
    localparam int FONT_DEPTH  = 480;
    localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
    localparam int FONT_AW     = $clog2(FONT_DEPTH);
    localparam int COL_W       = (GLYPH_W > 1) ? $clog2(GLYPH_W) : 1;
    localparam int FONT_IDX_W  = 13;

    localparam logic [7:0] SOLID_COLUMN = 8'hFF;
    localparam logic [7:0] GLYPH_ROWS   = 8'((9'd1 << (GLYPH_H + 1)) - 9'd1);

    localparam logic [2:0] OP_SET_PIXEL   = 3'd0;
    localparam logic [2:0] OP_CLEAR_PIXEL = 3'd1;
    localparam logic [2:0] OP_DRAW_GLYPH  = 3'd2;
    localparam logic [2:0] OP_LOAD_FONT   = 3'd3;
    localparam logic [2:0] OP_READ_FRAME  = 3'd4;
    localparam logic [2:0] OP_CLEAR_SCR   = 3'd5;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] char_code;
        logic       inverted;
        logic [8:0] font_addr;
        logic [7:0] font_column;
        logic [9:0] frame_addr;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       op_done;
    } out_item_t;

endpackage

[src/glyph_framebuffer_renderer.sv]
// Monochrome text renderer over a 1024-byte page-organized frame store (byte = page * width +
// column, bit = row mod 8) and a 480-byte font store. One item is worked at a time and each
// item gives one result; the frame store read-modify-write sets the pace. Load font and
// unknown operations go straight to the result, read frame byte reads and captures one byte,
// set or clear pixel does a read-modify-write of both page halves, draw glyph does per column
// a font read and two page read-modify-writes, and clear screen writes one frame byte per
// cycle. After reset the frame store is swept to zero, during which s_ready is low. A
// finished result waits in the output register while the next item is accepted.
`include "assert_macros.svh"

module glyph_framebuffer_renderer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gfr_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output gfr_pkg::out_item_t  m_item
);
    import gfr_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FONT  = 3'd2;
    localparam logic [2:0] S_PRD   = 3'd3;
    localparam logic [2:0] S_PWR   = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_RCAP  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [FRAME_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                  clr_resp_reg, clr_resp_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_item_reg;

    logic [7:0]            x_reg;
    logic [4:0]            page0_reg;
    logic [2:0]            shift_reg;
    logic [7:0]            row_en_reg;
    logic [7:0]            bits_reg;
    logic                  glyph_reg;
    logic                  known_reg;
    logic                  inv_reg;
    logic [11:0]           font_base_reg;
    logic [COL_W-1:0]      col_reg;
    logic [COL_W-1:0]      last_col_reg;
    logic                  half_reg;
    logic [FRAME_AW-1:0]   frame_addr_reg;
    logic [7:0]            result_byte_reg;

    logic [7:0]            frame_mem [FRAME_DEPTH];
    logic [7:0]            font_mem  [FONT_DEPTH];
    logic [7:0]            frame_rd_reg;
    logic [7:0]            font_rd_reg;

    logic                  accept;
    logic                  out_load;
    logic [8:0]            xcol;
    logic [5:0]            page;
    logic [15:0]           pix_addr_wide;
    logic                  col_ok;
    logic                  addr_ok;
    logic [7:0]            row_ok;
    logic [15:0]           en16;
    logic [15:0]           val16;
    logic [7:0]            wmask;
    logic [7:0]            wval;
    logic [FONT_IDX_W-1:0] font_idx;
    logic [7:0]            font_bits;
    logic                  frame_we;
    logic [FRAME_AW-1:0]   frame_waddr;
    logic [FRAME_AW-1:0]   frame_raddr;
    logic [7:0]            frame_wdata;
    logic                  font_we;
    logic                  code_known;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    assign code_known = (s_item.char_code >= 8'(FIRST_CODE))
                        && (s_item.char_code <= 8'(LAST_CODE));

    // pixel column, page and byte address for the current column and page half
    always_comb begin
        xcol          = 9'(x_reg) + 9'(col_reg);
        page          = 6'(page0_reg) + 6'(half_reg);
        pix_addr_wide = 16'(page) * 16'(DISP_W) + 16'(xcol);
        col_ok        = (xcol < 9'(DISP_W));
        addr_ok       = (pix_addr_wide < 16'(FRAME_DEPTH));
        for (int b = 0; b < 8; b++) begin
            row_ok[b] = (9'({page, 3'(b)}) < 9'(DISP_H));
        end
        en16  = 16'(row_en_reg) << shift_reg;
        val16 = 16'(bits_reg) << shift_reg;
        wmask = (half_reg ? en16[15:8] : en16[7:0]) & row_ok;
        wval  = half_reg ? val16[15:8] : val16[7:0];
    end

    // font column for the current glyph column
    always_comb begin
        font_idx = 13'(font_base_reg) + 13'(col_reg);
        if (!known_reg) begin
            font_bits = SOLID_COLUMN;
        end else if (font_idx < 13'(FONT_DEPTH)) begin
            font_bits = font_rd_reg;
        end else begin
            font_bits = 8'h00;
        end
    end

    // frame store port control
    always_comb begin
        frame_raddr = (state_reg == S_READ) ? frame_addr_reg : pix_addr_wide[FRAME_AW-1:0];
        if (state_reg == S_CLEAR) begin
            frame_we    = 1'b1;
            frame_waddr = clr_cnt_reg;
            frame_wdata = 8'h00;
        end else begin
            frame_we    = (state_reg == S_PWR) && col_ok && addr_ok;
            frame_waddr = pix_addr_wide[FRAME_AW-1:0];
            frame_wdata = (frame_rd_reg & ~wmask) | (wval & wmask);
        end
    end

    assign font_we = accept && (s_item.operation == OP_LOAD_FONT)
                     && (s_item.font_addr < 9'(FONT_DEPTH));

    always_ff @(posedge aclk) begin
        if (frame_we) begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
        frame_rd_reg <= frame_mem[frame_raddr];
    end

    always_ff @(posedge aclk) begin
        if (font_we) begin
            font_mem[s_item.font_addr[FONT_AW-1:0]] <= s_item.font_column;
        end
        font_rd_reg <= font_mem[font_idx[FONT_AW-1:0]];
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_resp_next = clr_resp_reg;
        m_valid_next  = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == FRAME_AW'(FRAME_DEPTH - 1)) begin
                    state_next    = clr_resp_reg ? S_DONE : S_IDLE;
                    clr_resp_next = 1'b0;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (s_item.operation)
                        OP_SET_PIXEL, OP_CLEAR_PIXEL: state_next = S_PRD;
                        OP_DRAW_GLYPH:                state_next = S_FONT;
                        OP_READ_FRAME:                state_next = S_READ;
                        OP_CLEAR_SCR: begin
                            state_next    = S_CLEAR;
                            clr_resp_next = 1'b1;
                        end
                        default:                      state_next = S_DONE;
                    endcase
                end
            end
            S_FONT:  state_next = S_PRD;
            S_PRD:   state_next = S_PWR;
            S_PWR: begin
                if (!half_reg) begin
                    state_next = S_PRD;
                end else if (col_reg == last_col_reg) begin
                    state_next = S_DONE;
                end else begin
                    state_next = glyph_reg ? S_FONT : S_PRD;
                end
            end
            S_READ:  state_next = S_RCAP;
            S_RCAP:  state_next = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            clr_resp_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_resp_reg <= clr_resp_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // work registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg           <= s_item.pos_x;
            page0_reg       <= s_item.pos_y[7:3];
            shift_reg       <= s_item.pos_y[2:0];
            frame_addr_reg  <= s_item.frame_addr;
            result_byte_reg <= 8'h00;
            col_reg         <= '0;
            half_reg        <= 1'b0;
            known_reg       <= code_known;
            inv_reg         <= s_item.inverted;
            font_base_reg   <= 12'(s_item.char_code - 8'(FIRST_CODE)) * 12'(GLYPH_W);
            if (s_item.operation == OP_DRAW_GLYPH) begin
                glyph_reg    <= 1'b1;
                row_en_reg   <= GLYPH_ROWS;
                last_col_reg <= COL_W'(GLYPH_W - 1);
                bits_reg     <= 8'h00;
            end else begin
                glyph_reg    <= 1'b0;
                row_en_reg   <= 8'h01;
                last_col_reg <= '0;
                bits_reg     <= (s_item.operation == OP_SET_PIXEL) ? 8'h01 : 8'h00;
            end
        end
        if (state_reg == S_PRD && glyph_reg && !half_reg) begin
            bits_reg <= font_bits ^ {8{inv_reg}};
        end
        if (state_reg == S_PWR) begin
            half_reg <= !half_reg;
            if (half_reg) begin
                col_reg <= col_reg + 1'b1;
            end
        end
        if (state_reg == S_RCAP) begin
            result_byte_reg <= frame_rd_reg;
        end
        if (out_load) begin
            m_item_reg.read_byte <= result_byte_reg;
            m_item_reg.op_done   <= 1'b1;
        end
    end

    `ASSERT_PROP(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "accepted while busy")
    `ASSERT_PROP(a_clear_cnt_rest, state_reg != S_CLEAR |-> clr_cnt_reg == '0, "clear count left over")
    `ASSERT_PROP(a_result_from_done, $rose(m_valid) |-> $past(state_reg == S_DONE), "result out of sequence")
    `ASSERT_NEVER(a_no_write_idle, s_ready && frame_we, "frame write while idle")

endmodule
